@@ design/otb_pkg.sv @@
// shared types and command codes for the timer bank
package otb_pkg;

  localparam logic [2:0] CMD_SERVICE    = 3'd0;
  localparam logic [2:0] CMD_REGISTER   = 3'd1;
  localparam logic [2:0] CMD_UNREGISTER = 3'd2;
  localparam logic [2:0] CMD_INTERVAL   = 3'd3;
  localparam logic [2:0] CMD_TIMEOUT    = 3'd4;
  localparam logic [2:0] CMD_CHPERIOD   = 3'd5;
  localparam logic [2:0] CMD_STOP       = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  slot;
    logic [31:0] value;
    logic [31:0] now;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] fired_slot;
    logic       last_event;
  } out_beat_t;

endpackage

@@ design/otb_expiry_unit.sv @@
// shared expiry compare: wrapped elapsed ticks against the slot period
module otb_expiry_unit #(
  parameter int TICK_BITS = 32
) (
  input  logic [TICK_BITS-1:0] now,
  input  logic [TICK_BITS-1:0] start,
  input  logic [TICK_BITS-1:0] period,
  output logic                 expired
);

  logic [TICK_BITS-1:0] elapsed;

  // subtraction wraps modulo 2^TICK_BITS by width
  assign elapsed = now - start;
  assign expired = (elapsed >= period);

endmodule

@@ design/one_shot_and_periodic_timer_bank.sv @@
// top level of the timer bank: command decode, slot storage and service scan
//
//   channel | ports                         | direction | carries
//   --------+-------------------------------+-----------+-------------------------------
//   input   | in_valid in_ready in_beat     | in        | command, slot, value, now
//   result  | out_valid out_ready out_beat  | out       | fired_slot, last_event
//
// non-service commands take effect in the cycle they are accepted
// a service beat scans one slot per cycle through the shared expiry compare, so in_ready
// stays low through the scan and through the finish state that hands over the last event
// each hit waits in a one-entry pending slot until the next hit or the end of the scan
// shows whether it is the final event; a full result register stalls the scan
// synchronous active-low reset clears the slot flags, the sequencer and the result register
module one_shot_and_periodic_timer_bank #(
  parameter int NUM_SLOTS = 16,
  parameter int TICK_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  otb_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output otb_pkg::out_beat_t out_beat
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // per-slot state; ticks need no reset since register always writes them first
  logic [NUM_SLOTS-1:0] listed_r;
  logic [NUM_SLOTS-1:0] armed_r;
  logic [NUM_SLOTS-1:0] repeats_r;
  logic [TICK_BITS-1:0] period_r [NUM_SLOTS];
  logic [TICK_BITS-1:0] start_r  [NUM_SLOTS];

  logic [1:0]           state_r, state_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [TICK_BITS-1:0] now_r;

  // pending event, held until we know whether another hit follows
  logic                 pend_v_r;
  logic [3:0]           pend_slot_r;

  logic                 out_valid_r;
  otb_pkg::out_beat_t   out_beat_r;

  // field reduction to the tick width and slot index width
  logic [63:0]          value_ext, now_ext;
  logic [TICK_BITS-1:0] value_t, now_t;
  logic [7:0]           slot_ext, idx_ext;
  logic [SLOT_W-1:0]    cmd_idx;
  logic                 slot_ok;
  logic                 accept;

  logic                 expired;
  logic                 hit;
  logic                 out_free;
  logic                 stall;
  logic                 push;
  logic                 push_last;
  logic                 scan_done;

  assign value_ext = {32'b0, in_beat.value};
  assign now_ext   = {32'b0, in_beat.now};
  assign value_t   = value_ext[TICK_BITS-1:0];
  assign now_t     = now_ext[TICK_BITS-1:0];
  assign slot_ext  = {4'b0, in_beat.slot};
  assign cmd_idx   = slot_ext[SLOT_W-1:0];
  assign slot_ok   = (32'(in_beat.slot) < NUM_SLOTS);
  assign idx_ext   = {{(8-SLOT_W){1'b0}}, idx_r};

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;

  otb_expiry_unit #(
    .TICK_BITS(TICK_BITS)
  ) u_expiry (
    .now    (now_r),
    .start  (start_r[idx_r]),
    .period (period_r[idx_r]),
    .expired(expired)
  );

  assign hit       = (state_r == ST_SCAN) && listed_r[idx_r] && armed_r[idx_r] && expired;
  assign out_free  = !out_valid_r || out_ready;
  // a second hit needs the pending event to move out first
  assign stall     = hit && pend_v_r && !out_free;
  assign scan_done = (32'(idx_r) == NUM_SLOTS - 1);
  assign push      = ((state_r == ST_SCAN) && hit && pend_v_r && !stall) ||
                     ((state_r == ST_FINISH) && pend_v_r && out_free);
  assign push_last = (state_r == ST_FINISH);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_beat.command == otb_pkg::CMD_SERVICE) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (scan_done) begin
            state_nxt = ST_FINISH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!pend_v_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      listed_r    <= '0;
      armed_r     <= '0;
      repeats_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;

      // command decode; slot indexes past the bank are dropped
      if (accept && in_beat.command != otb_pkg::CMD_SERVICE && slot_ok) begin
        case (in_beat.command)
          otb_pkg::CMD_REGISTER: begin
            listed_r[cmd_idx] <= 1'b1;
            armed_r[cmd_idx]  <= 1'b0;
          end
          otb_pkg::CMD_UNREGISTER: begin
            listed_r[cmd_idx] <= 1'b0;
          end
          otb_pkg::CMD_INTERVAL: begin
            armed_r[cmd_idx]   <= 1'b1;
            repeats_r[cmd_idx] <= 1'b1;
          end
          otb_pkg::CMD_TIMEOUT: begin
            armed_r[cmd_idx]   <= 1'b1;
            repeats_r[cmd_idx] <= 1'b0;
          end
          otb_pkg::CMD_STOP: begin
            armed_r[cmd_idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      // one-shot slots disarm when they fire
      if (hit && !stall && !repeats_r[idx_r]) begin
        armed_r[idx_r] <= 1'b0;
      end

      if (hit && !stall) begin
        pend_v_r <= 1'b1;
      end else if (state_r == ST_FINISH && out_free) begin
        pend_v_r <= 1'b0;
      end

      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // tick storage and payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= now_t;
    end
    if (accept && in_beat.command != otb_pkg::CMD_SERVICE && slot_ok) begin
      case (in_beat.command)
        otb_pkg::CMD_REGISTER: begin
          period_r[cmd_idx] <= '0;
          start_r[cmd_idx]  <= '0;
        end
        otb_pkg::CMD_INTERVAL, otb_pkg::CMD_TIMEOUT: begin
          period_r[cmd_idx] <= value_t;
          start_r[cmd_idx]  <= now_t;
        end
        otb_pkg::CMD_CHPERIOD: begin
          period_r[cmd_idx] <= value_t;
        end
        otb_pkg::CMD_STOP: begin
          period_r[cmd_idx] <= '0;
        end
        default: begin
        end
      endcase
    end
    // a fired slot restarts its period at the service tick
    if (hit && !stall) begin
      start_r[idx_r] <= now_r;
      pend_slot_r    <= idx_ext[3:0];
    end
    if (push) begin
      out_beat_r.fired_slot <= pend_slot_r;
      out_beat_r.last_event <= push_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // nothing may be left pending once the sequencer is back at rest
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("pending event left behind after service");

  // a held result must never be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !push)
    else $error("result register overwritten while stalled");

  // an accepted service starts the scan at slot zero
  a_service_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_beat.command == otb_pkg::CMD_SERVICE) |=>
      (state_r == ST_SCAN && idx_r == '0))
    else $error("service beat did not start the scan");

endmodule
